[hw/rtl/cgs_pkg.sv]
// package: field widths, opcodes and the microcode table of the grlex successor unit
`timescale 1ns / 1ps
`default_nettype none

package cgs_pkg;

    // parameter defaults
    localparam int MAX_PARTS_DEF = 16;
    localparam int PART_BITS_DEF = 16;

    // fixed beat field widths
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 4;
    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 5;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd3;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ADVANCE = 2'd2;

    // microprogram counter
    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t S_IDLE       = 5'd0;
    localparam upc_t S_SCAN_RD    = 5'd1;
    localparam upc_t S_SCAN_CHK   = 5'd2;
    localparam upc_t S_SCAN_NEXT  = 5'd3;
    localparam upc_t S_ALLZERO    = 5'd4;
    localparam upc_t S_FOUND      = 5'd5;
    localparam upc_t S_LEFT_RD    = 5'd6;
    localparam upc_t S_LEFT_CHK   = 5'd7;
    localparam upc_t S_LEFT_WR    = 5'd8;
    localparam upc_t S_POS_WR     = 5'd9;
    localparam upc_t S_LAST_WR    = 5'd10;
    localparam upc_t S_FIRST_CHK  = 5'd11;
    localparam upc_t S_FIRST_WR   = 5'd12;
    localparam upc_t S_FIRST_LAST = 5'd13;
    localparam upc_t S_OVF        = 5'd14;
    localparam upc_t S_REP_RD     = 5'd15;
    localparam upc_t S_REP_EMIT   = 5'd16;
    localparam upc_t S_REP_NEXT   = 5'd17;

    // control word fields
    typedef enum logic [1:0] {
        A_K,
        A_KM1,
        A_LAST
    } addr_sel_t;

    typedef enum logic [2:0] {
        WD_ZERO,
        WD_ONE,
        WD_RD_INC,
        WD_T_DEC,
        WD_T_INC
    } wd_sel_t;

    typedef enum logic [1:0] {
        K_HOLD,
        K_ZERO,
        K_DEC,
        K_INC
    } kop_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_RD_NZ,
        C_K_NZ,
        C_K_ZERO,
        C_RD_MAX,
        C_T_MAX,
        C_K_LAST
    } cond_t;

    typedef struct packed {
        addr_sel_t addr_sel;
        logic      we;
        wd_sel_t   wd_sel;
        kop_t      kop;
        cond_t     cond;
        upc_t      target;
        logic      latch_t;
        logic      set_ovf;
        logic      emit;
        logic      dispatch;
    } ctl_t;

    // microcode rom
    function automatic ctl_t cgs_ucode(input upc_t step);
        ctl_t c;
        c = '{addr_sel: A_K, we: 1'b0, wd_sel: WD_ZERO, kop: K_HOLD, cond: C_NEXT,
              target: S_IDLE, latch_t: 1'b0, set_ovf: 1'b0, emit: 1'b0, dispatch: 1'b0};
        unique case (step)
            S_IDLE:       c.dispatch = 1'b1;
            S_SCAN_RD:    ;
            S_SCAN_CHK:
            begin
                c.cond   = C_RD_NZ;
                c.target = S_FOUND;
            end
            S_SCAN_NEXT:
            begin
                c.kop    = K_DEC;
                c.cond   = C_K_NZ;
                c.target = S_SCAN_RD;
            end
            S_ALLZERO:
            begin
                c.addr_sel = A_LAST;
                c.we       = 1'b1;
                c.wd_sel   = WD_ONE;
                c.kop      = K_ZERO;
                c.cond     = C_ALWAYS;
                c.target   = S_REP_RD;
            end
            S_FOUND:
            begin
                c.latch_t = 1'b1;
                c.cond    = C_K_ZERO;
                c.target  = S_FIRST_CHK;
            end
            S_LEFT_RD:    c.addr_sel = A_KM1;
            S_LEFT_CHK:
            begin
                c.addr_sel = A_KM1;
                c.cond     = C_RD_MAX;
                c.target   = S_OVF;
            end
            S_LEFT_WR:
            begin
                c.addr_sel = A_KM1;
                c.we       = 1'b1;
                c.wd_sel   = WD_RD_INC;
            end
            S_POS_WR:
            begin
                c.we     = 1'b1;
                c.wd_sel = WD_ZERO;
            end
            S_LAST_WR:
            begin
                c.addr_sel = A_LAST;
                c.we       = 1'b1;
                c.wd_sel   = WD_T_DEC;
                c.kop      = K_ZERO;
                c.cond     = C_ALWAYS;
                c.target   = S_REP_RD;
            end
            S_FIRST_CHK:
            begin
                c.cond   = C_T_MAX;
                c.target = S_OVF;
            end
            S_FIRST_WR:
            begin
                c.we     = 1'b1;
                c.wd_sel = WD_ZERO;
            end
            S_FIRST_LAST:
            begin
                c.addr_sel = A_LAST;
                c.we       = 1'b1;
                c.wd_sel   = WD_T_INC;
                c.kop      = K_ZERO;
                c.cond     = C_ALWAYS;
                c.target   = S_REP_RD;
            end
            S_OVF:
            begin
                c.set_ovf = 1'b1;
                c.kop     = K_ZERO;
            end
            S_REP_RD:     ;
            S_REP_EMIT:
            begin
                c.emit   = 1'b1;
                c.cond   = C_K_LAST;
                c.target = S_IDLE;
            end
            S_REP_NEXT:
            begin
                c.kop    = K_INC;
                c.cond   = C_ALWAYS;
                c.target = S_REP_RD;
            end
            default:
            begin
                c.cond   = C_ALWAYS;
                c.target = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cgs_if.sv]
// channel interfaces: command beats, result beats and part count writes
`timescale 1ns / 1ps
`default_nettype none

interface cgs_item_if;
    import cgs_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  part_index;
    logic [VALUE_W-1:0]  part_value;

    modport source (output valid, output opcode, output part_index, output part_value,
                    input ready);
    modport sink   (input valid, input opcode, input part_index, input part_value,
                    output ready);
endinterface

interface cgs_result_if;
    import cgs_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] out_index;
    logic [VALUE_W-1:0] out_value;
    logic               overflow;
    logic               last;

    modport source (output valid, output out_index, output out_value, output overflow,
                    output last, input ready);
    modport sink   (input valid, input out_index, input out_value, input overflow,
                    input last, output ready);
endinterface

interface cgs_cfg_if;
    import cgs_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] part_count;

    modport source (output valid, output part_count, input ready);
    modport sink   (input valid, input part_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/composition_grlex_successor_unit.sv]
// top level: composition successor in graded lexicographic order, microcoded
//
// channels: item (command beats: opcode, part_index, part_value), result (one
// beat per active part: out_index, out_value, overflow, last) and cfg (writes of
// part_count, always ready; write it only while the unit is idle)
// restart clears every part and reports the active ones; load writes one part
// and reports nothing; advance steps to the successor and reports the active
// parts, with overflow set on every beat and the parts kept when one would wrap
// timing: a command is taken only in the idle step; load and unused opcodes go
// straight back to idle. a restart enters the report loop, which reads, emits and
// steps over each active part until the beat flagged last; its first result beat
// passes the read step and the emit step into the result register. an advance
// first scans from the right end (read, check, next) to the first nonzero part
// or past the left end, then runs the update steps and the report loop. the pace
// comes from the memory's single read port, one access per microcode step
// reset clears all parts through per-entry valid bits at once, sets part_count
// to 3 and returns the sequencer to idle; no clearing pass is needed
// a stalled receiver holds the result register and freezes the program counter
// in the emit step, nothing is lost or repeated
`timescale 1ns / 1ps
`default_nettype none

module composition_grlex_successor_unit #(
    parameter int MAX_PARTS = cgs_pkg::MAX_PARTS_DEF,
    parameter int PART_BITS = cgs_pkg::PART_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    cgs_cfg_if.sink      cfg,
    cgs_item_if.sink     item,
    cgs_result_if.source result
);
    import cgs_pkg::*;

    localparam int AW    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CNT_W = ($clog2(MAX_PARTS + 1) > COUNT_W) ? $clog2(MAX_PARTS + 1) : COUNT_W;

    // control state
    upc_t                upc_reg, upc_next;
    logic [AW-1:0]       k_reg, k_next;
    logic                ovf_reg, ovf_next;
    logic [MAX_PARTS-1:0] valid_reg, valid_next;
    logic [COUNT_W-1:0]  part_count_reg, part_count_next;
    logic                out_valid_reg, out_valid_next;

    // payload
    logic [PART_BITS-1:0] t_reg;
    logic [PART_BITS-1:0] rd_data_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic                 out_ovf_reg;
    logic                 out_last_reg;

    // part memory
    logic [PART_BITS-1:0] mem [MAX_PARTS];

    ctl_t                 ctl;
    logic                 item_fire;
    logic                 emit_go;
    logic                 cond_true;
    logic                 k_last;
    logic [CNT_W-1:0]     pc_ext;
    logic [AW-1:0]        last_idx;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [PART_BITS-1:0] wr_data;
    logic                 wr_en;
    logic                 load_hit;

    assign ctl       = cgs_ucode(upc_reg);
    assign item_fire = item.valid && item.ready;
    assign emit_go   = ctl.emit && (!out_valid_reg || result.ready);

    assign cfg.ready  = 1'b1;
    assign item.ready = (upc_reg == S_IDLE);

    assign result.valid     = out_valid_reg;
    assign result.out_index = out_index_reg;
    assign result.out_value = out_value_reg;
    assign result.overflow  = out_ovf_reg;
    assign result.last      = out_last_reg;

    // active part count, zero acts as one, clamped to the storage depth
    assign pc_ext = CNT_W'(part_count_reg);
    always_comb
    begin
        priority if (pc_ext == '0)
            last_idx = '0;
        else if (pc_ext >= CNT_W'(MAX_PARTS))
            last_idx = AW'(MAX_PARTS - 1);
        else
            last_idx = AW'(pc_ext - CNT_W'(1));
    end

    assign k_last = (k_reg == last_idx);

    // jump condition of the current step
    always_comb
    begin
        unique case (ctl.cond)
            C_NEXT:   cond_true = 1'b0;
            C_ALWAYS: cond_true = 1'b1;
            C_RD_NZ:  cond_true = (rd_data_reg != '0);
            C_K_NZ:   cond_true = (k_reg != '0);
            C_K_ZERO: cond_true = (k_reg == '0);
            C_RD_MAX: cond_true = &rd_data_reg;
            C_T_MAX:  cond_true = &t_reg;
            C_K_LAST: cond_true = k_last;
            default:  cond_true = 1'b0;
        endcase
    end

    // memory addressing and write data
    always_comb
    begin
        unique case (ctl.addr_sel)
            A_K:     rd_addr = k_reg;
            A_KM1:   rd_addr = k_reg - AW'(1);
            A_LAST:  rd_addr = last_idx;
            default: rd_addr = k_reg;
        endcase
    end

    assign load_hit = ctl.dispatch && item_fire && (item.opcode == OP_LOAD)
                      && (int'(item.part_index) < MAX_PARTS);

    always_comb
    begin
        unique case (ctl.wd_sel)
            WD_ZERO:   wr_data = '0;
            WD_ONE:    wr_data = PART_BITS'(1);
            WD_RD_INC: wr_data = rd_data_reg + PART_BITS'(1);
            WD_T_DEC:  wr_data = t_reg - PART_BITS'(1);
            WD_T_INC:  wr_data = t_reg + PART_BITS'(1);
            default:   wr_data = '0;
        endcase
        wr_addr = rd_addr;
        wr_en   = ctl.we;
        if (load_hit)
        begin
            wr_addr = AW'(item.part_index);
            wr_data = PART_BITS'(item.part_value);
            wr_en   = 1'b1;
        end
    end

    // sequencer next state
    always_comb
    begin
        upc_next        = cond_true ? ctl.target : upc_reg + UPC_W'(1);
        k_next          = k_reg;
        ovf_next        = ovf_reg | ctl.set_ovf;
        valid_next      = valid_reg;
        part_count_next = part_count_reg;
        out_valid_next  = out_valid_reg && !result.ready;

        unique case (ctl.kop)
            K_HOLD:  k_next = k_reg;
            K_ZERO:  k_next = '0;
            K_DEC:   k_next = k_reg - AW'(1);
            K_INC:   k_next = k_reg + AW'(1);
            default: k_next = k_reg;
        endcase

        if (ctl.dispatch)
        begin
            upc_next = S_IDLE;
            if (item_fire)
            begin
                priority case (item.opcode)
                    OP_RESTART:
                    begin
                        upc_next   = S_REP_RD;
                        k_next     = '0;
                        ovf_next   = 1'b0;
                        valid_next = '0;
                    end
                    OP_ADVANCE:
                    begin
                        upc_next = S_SCAN_RD;
                        k_next   = last_idx;
                        ovf_next = 1'b0;
                    end
                    default:    upc_next = S_IDLE;
                endcase
            end
        end

        // receiver stall freezes the emit step
        if (ctl.emit && !emit_go)
            upc_next = upc_reg;
        if (emit_go)
            out_valid_next = 1'b1;

        if (wr_en)
            valid_next[wr_addr] = 1'b1;

        if (cfg.valid && cfg.ready)
            part_count_next = cfg.part_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= S_IDLE;
            k_reg          <= '0;
            ovf_reg        <= 1'b0;
            valid_reg      <= '0;
            part_count_reg <= COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            upc_reg        <= upc_next;
            k_reg          <= k_next;
            ovf_reg        <= ovf_next;
            valid_reg      <= valid_next;
            part_count_reg <= part_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctl.latch_t)
            t_reg <= rd_data_reg;
        if (emit_go)
        begin
            out_index_reg <= INDEX_W'(k_reg);
            out_value_reg <= VALUE_W'(rd_data_reg);
            out_ovf_reg   <= ovf_reg;
            out_last_reg  <= k_last;
        end
    end

    // part memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

`ifndef SYNTHESIS
    // report index never runs past the active parts
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == S_REP_EMIT) |-> (k_reg <= last_idx))
        else $error("report index beyond active parts");

    // the beat flagged last ends the run
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && k_last) |=> (upc_reg == S_IDLE))
        else $error("sequencer did not return to idle after last beat");

    // memory writes stay inside the storage depth
    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (int'(wr_addr) < MAX_PARTS))
        else $error("part write out of range");

    // restart empties every stored part
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item.opcode == OP_RESTART) |=> (valid_reg == '0))
        else $error("restart did not clear parts");

    // a new beat is only produced while the result register can take it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(out_value_reg)))
        else $error("pending result beat overwritten");
`endif

endmodule

`default_nettype wire

[test/composition_grlex_successor_unit_test.sv]
// testbench for the grlex composition successor unit: directed and random beats, scoreboard check
`timescale 1ns / 1ps

// one expected result beat
typedef struct {
    logic [cgs_pkg::INDEX_W-1:0] index;
    logic [cgs_pkg::VALUE_W-1:0] value;
    logic                        overflow;
    logic                        last;
} part_beat_t;

// mirror of the part store and the part count, plus the queue of beats still owed
class grlex_scoreboard;
    typedef logic [cgs_pkg::VALUE_W:0] wide_t;

    logic [cgs_pkg::VALUE_W-1:0] parts [16];
    logic [cgs_pkg::COUNT_W-1:0] part_count;
    part_beat_t                  owed_beats [$];
    int                          mismatches;

    function new();
        part_count = cgs_pkg::COUNT_RESET;
        mismatches = 0;
        foreach (parts[j]) parts[j] = '0;
    endfunction

    function int pending();
        return owed_beats.size();
    endfunction

    // 0 acts as 1, anything above 16 acts as 16
    function int active_parts();
        if (part_count == 0) return 1;
        if (part_count > 16) return 16;
        return int'(part_count);
    endfunction

    // step to the successor; returns 1 and keeps the parts when one would wrap
    function bit advance_parts(input int kc);
        wide_t work [16];
        wide_t t;
        int    pos;
        int    j;
        for (j = 0; j < 16; j++) work[j] = {1'b0, parts[j]};
        pos = 0;
        for (j = kc; j >= 1 && pos == 0; j--)
            if (work[j-1] != '0) pos = j;
        if (pos == 0)
            work[kc-1] = wide_t'(1);
        else if (pos == 1)
        begin
            t = work[0] + wide_t'(1);
            work[0] = '0;
            work[kc-1] = t;
        end
        else
        begin
            t = work[pos-1];
            work[pos-1] = '0;
            work[pos-2] = work[pos-2] + wide_t'(1);
            work[kc-1] = work[kc-1] + t - wide_t'(1);
        end
        for (j = 0; j < kc; j++)
            if (work[j][cgs_pkg::VALUE_W]) return 1'b1;
        for (j = 0; j < 16; j++) parts[j] = work[j][cgs_pkg::VALUE_W-1:0];
        return 1'b0;
    endfunction

    function void owe_report(input int kc, input logic ovf);
        part_beat_t b;
        int         k;
        for (k = 0; k < kc; k++)
        begin
            b.index    = k[cgs_pkg::INDEX_W-1:0];
            b.value    = parts[k];
            b.overflow = ovf;
            b.last     = (k == kc - 1);
            owed_beats.push_back(b);
        end
    endfunction

    // accepted command beat
    function void note_item(input logic [cgs_pkg::OPCODE_W-1:0] op,
                            input logic [cgs_pkg::INDEX_W-1:0] idx,
                            input logic [cgs_pkg::VALUE_W-1:0] val);
        int kc;
        bit ovf;
        kc = active_parts();
        case (op)
            cgs_pkg::OP_RESTART:
            begin
                foreach (parts[j]) parts[j] = '0;
                owe_report(kc, 1'b0);
            end
            cgs_pkg::OP_LOAD:    parts[idx] = val;
            cgs_pkg::OP_ADVANCE:
            begin
                ovf = advance_parts(kc);
                owe_report(kc, ovf);
            end
            default:             ;
        endcase
    endfunction

    // accepted result beat against the oldest owed one
    function void check_result(input logic [cgs_pkg::INDEX_W-1:0] idx,
                               input logic [cgs_pkg::VALUE_W-1:0] val,
                               input logic ovf, input logic fin);
        part_beat_t b;
        if (owed_beats.size() == 0)
        begin
            $error("unexpected result beat: out_index %0d out_value %0h", idx, val);
            mismatches++;
            return;
        end
        b = owed_beats.pop_front();
        if (idx !== b.index)
        begin
            $error("out_index: expected %0d, actual %0d", b.index, idx);
            mismatches++;
        end
        if (val !== b.value)
        begin
            $error("out_value: expected %0h, actual %0h", b.value, val);
            mismatches++;
        end
        if (ovf !== b.overflow)
        begin
            $error("overflow: expected %0b, actual %0b", b.overflow, ovf);
            mismatches++;
        end
        if (fin !== b.last)
        begin
            $error("last: expected %0b, actual %0b", b.last, fin);
            mismatches++;
        end
    endfunction
endclass

module composition_grlex_successor_unit_test;
    import cgs_pkg::*;

    // the package names no code for the spare opcode
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 425;
    localparam int IDLE_MAX      = 13;
    // well past the longest busy stretch of the unit
    localparam int SETTLE_CYCLES = 200;
    localparam int DRAIN_LIMIT   = 20000;
    // worst run: ~500 commands x 16 beats, each with its receiver stall and its work, plus gaps, taken ~5x
    localparam int TIMEOUT_NS    = 12_000_000;

    logic clk;
    logic rst_n;

    cgs_cfg_if    cfg_bus ();
    cgs_item_if   item_bus ();
    cgs_result_if result_bus ();

    composition_grlex_successor_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .item   (item_bus),
        .result (result_bus)
    );

    grlex_scoreboard board;

    // sender runs without gaps while this is set
    bit tx_steady;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one command beat; valid stays high between back-to-back beats so it
    // never sees two assignments in one step
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] val);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.opcode     <= op;
        item_bus.part_index <= idx;
        item_bus.part_value <= val;
        @(posedge clk);
        while (!item_bus.ready) @(posedge clk);
        board.note_item(op, idx, val);
    endtask

    // part count write; only called while the unit is idle
    task automatic write_count(input logic [COUNT_W-1:0] count);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.part_count <= count;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        board.part_count = count;
        cfg_bus.valid <= 1'b0;
    endtask

    // hold the sender until every owed beat is back, then let the unit settle
    task automatic drain_results(input int settle);
        int waited;
        item_bus.valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (board.pending() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (settle) @(posedge clk);
    endtask

    // mostly advances over small parts so the walk goes deep into each degree;
    // loads near the top of the range provoke overflow now and then
    task automatic random_item(output bit counted);
        int                  pick;
        int                  vsel;
        logic [OPCODE_W-1:0] op;
        logic [INDEX_W-1:0]  idx;
        logic [VALUE_W-1:0]  val;
        pick = $urandom_range(0, 99);
        vsel = $urandom_range(0, 99);
        idx  = INDEX_W'($urandom_range(0, 15));
        if (vsel < 75)
            val = VALUE_W'($urandom_range(0, 3));
        else if (vsel < 85)
            val = 16'hFFFF - VALUE_W'($urandom_range(0, 1));
        else
            val = VALUE_W'($urandom_range(0, 16'hFFFF));
        if (pick < 8)
            op = OP_RESTART;
        else if (pick < 30)
            op = OP_LOAD;
        else if (pick < 34)
            op = OP_UNUSED;
        else
            op = OP_ADVANCE;
        send_item(op, idx, val);
        counted = (op != OP_UNUSED);
    endtask

    // result side: random stall before each beat, with stretches of none
    initial
    begin : result_sink
        int stall;
        bit rx_steady;
        rx_steady = 1'b0;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0) rx_steady = ~rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, IDLE_MAX);
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge clk);
            while (!result_bus.valid) @(posedge clk);
            board.check_result(result_bus.out_index, result_bus.out_value,
                               result_bus.overflow, result_bus.last);
        end
    end

    initial
    begin : stimulus
        int                 done;
        int                 phase;
        int                 phase_len;
        int                 k;
        bit                 counted;
        logic [COUNT_W-1:0] count;

        board     = new();
        tx_steady = 1'b0;

        // every input known from time zero, reset asserted at the start
        rst_n               <= 1'b0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.part_count  <= '0;
        item_bus.valid      <= 1'b0;
        item_bus.opcode     <= OP_RESTART;
        item_bus.part_index <= '0;
        item_bus.part_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, part count still at its reset value of 3
        // first advance from all zeros sets the last part to 1
        send_item(OP_ADVANCE, 4'd0, 16'd0);
        send_item(OP_ADVANCE, 4'd0, 16'd0);
        send_item(OP_ADVANCE, 4'd0, 16'd0);
        send_item(OP_ADVANCE, 4'd0, 16'd0);
        // first part at full scale: first-part step would wrap
        send_item(OP_LOAD, 4'd0, 16'hFFFF);
        send_item(OP_LOAD, 4'd1, 16'd0);
        send_item(OP_LOAD, 4'd2, 16'd0);
        send_item(OP_ADVANCE, 4'd0, 16'd0);
        // left neighbour at full scale: its increment would wrap
        send_item(OP_LOAD, 4'd1, 16'd5);
        send_item(OP_ADVANCE, 4'd0, 16'd0);
        // spare opcode with loud payload is ignored
        send_item(OP_UNUSED, 4'd15, 16'hFFFF);
        send_item(OP_RESTART, 4'd0, 16'd0);
        // loads beyond the active count, seen once the count grows, and one inside it
        send_item(OP_LOAD, 4'd15, 16'h8001);
        send_item(OP_LOAD, 4'd7, 16'h5555);
        send_item(OP_LOAD, 4'd1, 16'h1234);
        send_item(OP_ADVANCE, 4'd0, 16'd0);

        // largest count: rightmost nonzero is the last part itself
        drain_results(SETTLE_CYCLES);
        write_count(5'd16);
        send_item(OP_ADVANCE, 4'd0, 16'd0);

        // count 0 behaves as a single part
        drain_results(SETTLE_CYCLES);
        write_count(5'd0);
        send_item(OP_ADVANCE, 4'd0, 16'd0);
        send_item(OP_LOAD, 4'd0, 16'hFFFF);
        send_item(OP_ADVANCE, 4'd0, 16'd0);

        // count above the part store clamps to 16
        drain_results(SETTLE_CYCLES);
        write_count(5'd31);
        send_item(OP_RESTART, 4'd0, 16'd0);
        send_item(OP_ADVANCE, 4'd0, 16'd0);

        // random phases, each under its own part count, extremes first
        done  = 0;
        phase = 0;
        while (done < RANDOM_ITEMS)
        begin
            drain_results(SETTLE_CYCLES);
            case (phase)
                0:       count = 5'd1;
                1:       count = 5'd16;
                2:       count = 5'd0;
                3:       count = 5'd31;
                4:       count = 5'd2;
                5:       count = 5'd15;
                default: count = COUNT_W'($urandom_range(0, 31));
            endcase
            write_count(count);
            tx_steady = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 60);
            for (k = 0; k < phase_len && done < RANDOM_ITEMS; k++)
            begin
                // now and then hold off until the receiver has caught up
                if ($urandom_range(0, 59) == 0) drain_results(0);
                random_item(counted);
                if (counted) done++;
            end
            phase++;
        end

        drain_results(SETTLE_CYCLES);
        if (board.pending() != 0)
        begin
            $error("%0d result beats expected but never seen", board.pending());
            board.mismatches++;
        end
        if (board.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
